### design/sbc_pkg.sv
// Shared types and constants for the sprite blitter with clipping and wraparound.
// Holds the input and result beat structs, command, rule and register codes.
// No dependencies.
package sbc_pkg;

	localparam int ARRAY_COLS_DEF = 64;
	localparam int ARRAY_ROWS_DEF = 64;

	localparam int COORD_W    = 6;
	localparam int PIX_W      = 8;
	localparam int TAG_W      = 8;
	localparam int ORIGIN_W   = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;
	localparam int MODE_W     = 3;

	// Magnitude of (origin + offset - window min) fits in eight bits.
	localparam int MAG_W     = 8;
	localparam int DIV_STEPS = MAG_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic CMD_PLACE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	localparam logic [1:0] RULE_COPY      = 2'd0;
	localparam logic [1:0] RULE_SKIP_ZERO = 2'd1;
	localparam logic [1:0] RULE_OR        = 2'd2;

	localparam int MODE_TOR_BIT = 2;

	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_X_MIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_X_MAX  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_Y_MIN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_Y_MAX  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_REF_NUMBER = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_PLACE_MODE = 3'd7;

	typedef struct packed {
		logic               cmd;
		logic [PIX_W-1:0]   pixel_value;
		logic [COORD_W-1:0] obj_col;
		logic [COORD_W-1:0] obj_row;
		logic [COORD_W-1:0] cell_x;
		logic [COORD_W-1:0] cell_y;
	} sbc_in_t;

	typedef struct packed {
		logic [COORD_W-1:0] dest_x;
		logic [COORD_W-1:0] dest_y;
		logic [PIX_W-1:0]   cell_pixel;
		logic [TAG_W-1:0]   cell_tag;
		logic               in_window;
	} sbc_out_t;

endpackage

### design/sprite_blit_clip_wrap_core.sv
// Sprite blitter core: one item at a time, read-modify-write on a combined pixel/tag memory.
// Steps: prepare, then for toroidal placement 8 remainder steps plus a fix-up, then a bounds
// check, a memory read and the registered result; a clipped result skips the read, and an
// empty window also skips the remainder. Input is ready again only once the result registers,
// so no new item is taken before the last is through; a stalled result holds it back.
// Reset starts a clearing pass that zeroes every memory entry; input waits, config is taken.
module sprite_blit_clip_wrap_core #(
	parameter int ARRAY_COLS = sbc_pkg::ARRAY_COLS_DEF,
	parameter int ARRAY_ROWS = sbc_pkg::ARRAY_ROWS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sbc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sbc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  sbc_pkg::sbc_in_t                in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output sbc_pkg::sbc_out_t               out_data
);

	localparam int DEPTH  = ARRAY_COLS * ARRAY_ROWS;
	localparam int AW     = $clog2(DEPTH);
	localparam int CW     = sbc_pkg::COORD_W;
	localparam int PW     = sbc_pkg::PIX_W;
	localparam int TW     = sbc_pkg::TAG_W;
	localparam int MW     = sbc_pkg::MAG_W;
	localparam int DCW    = sbc_pkg::DIV_CNT_W;
	localparam int WW     = CW + 1;
	localparam int DW     = sbc_pkg::ORIGIN_W + 1;
	localparam int VW     = DW + 1;

	typedef enum logic [7:0] {
		S_CLR  = 8'b0000_0001,
		S_IDLE = 8'b0000_0010,
		S_PREP = 8'b0000_0100,
		S_DIV  = 8'b0000_1000,
		S_FIX  = 8'b0001_0000,
		S_CHK  = 8'b0010_0000,
		S_READ = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic signed [sbc_pkg::ORIGIN_W-1:0] origin_x_q, origin_y_q;
	logic [CW-1:0]                       win_x_min_q, win_x_max_q, win_y_min_q, win_y_max_q;
	logic [TW-1:0]                       ref_number_q;
	logic [sbc_pkg::MODE_W-1:0]          place_mode_q;

	sbc_pkg::sbc_in_t  item_q;
	sbc_pkg::sbc_out_t out_q;
	logic              out_valid_q;

	logic [AW-1:0]     clr_q;
	logic [AW-1:0]     addr_q;
	logic [CW-1:0]     x_q, y_q;
	logic              ok_q;

	logic [DCW-1:0]    div_cnt_q;
	logic [MW-1:0]     dvd_x_q, dvd_y_q;
	logic [CW-1:0]     rem_x_q, rem_y_q;
	logic              neg_x_q, neg_y_q;

	logic [PW+TW-1:0]  mem_q [DEPTH];
	logic [PW+TW-1:0]  rd_q;

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [PW+TW-1:0]  mem_wdata;

	logic              in_fire;
	logic              done_fire;
	logic              is_place;
	logic              tor;

	logic signed [DW-1:0] dx, dy;
	logic signed [VW-1:0] vx, vy, nvx, nvy;
	logic [MW-1:0]        mag_x, mag_y;
	logic                 empty_x, empty_y, inwin_x, inwin_y;
	logic [WW-1:0]        w_x, w_y;
	logic [WW-1:0]        t_x, t_y, ts_x, ts_y;
	logic [WW-1:0]        r_x, r_y, fx, fy;
	logic                 bounds_ok;
	logic [AW-1:0]        addr_calc;
	logic [PW-1:0]        old_pix, new_pix;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign done_fire = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign is_place  = (item_q.cmd == sbc_pkg::CMD_PLACE);
	assign tor       = place_mode_q[sbc_pkg::MODE_TOR_BIT];

	// Destination before windowing, and its offset from the window minimum.
	always_comb begin
		dx  = $signed({origin_x_q[sbc_pkg::ORIGIN_W-1], origin_x_q})
			+ $signed({{(DW-CW){1'b0}}, item_q.obj_col});
		dy  = $signed({origin_y_q[sbc_pkg::ORIGIN_W-1], origin_y_q})
			+ $signed({{(DW-CW){1'b0}}, item_q.obj_row});
		vx  = $signed({dx[DW-1], dx}) - $signed({{(VW-CW){1'b0}}, win_x_min_q});
		vy  = $signed({dy[DW-1], dy}) - $signed({{(VW-CW){1'b0}}, win_y_min_q});
		nvx = -vx;
		nvy = -vy;
		mag_x = vx[VW-1] ? nvx[MW-1:0] : vx[MW-1:0];
		mag_y = vy[VW-1] ? nvy[MW-1:0] : vy[MW-1:0];
		empty_x = win_x_min_q > win_x_max_q;
		empty_y = win_y_min_q > win_y_max_q;
		inwin_x = !empty_x && (dx >= $signed({{(DW-CW){1'b0}}, win_x_min_q}))
			&& (dx <= $signed({{(DW-CW){1'b0}}, win_x_max_q}));
		inwin_y = !empty_y && (dy >= $signed({{(DW-CW){1'b0}}, win_y_min_q}))
			&& (dy <= $signed({{(DW-CW){1'b0}}, win_y_max_q}));
		w_x = {1'b0, win_x_max_q} - {1'b0, win_x_min_q} + WW'(1);
		w_y = {1'b0, win_y_max_q} - {1'b0, win_y_min_q} + WW'(1);
	end

	// One restoring remainder step per cycle on each axis.
	always_comb begin
		t_x  = {rem_x_q, dvd_x_q[MW-1]};
		t_y  = {rem_y_q, dvd_y_q[MW-1]};
		ts_x = (t_x >= w_x) ? (t_x - w_x) : t_x;
		ts_y = (t_y >= w_y) ? (t_y - w_y) : t_y;
	end

	// A negative offset with a nonzero remainder folds back from the top of the window.
	always_comb begin
		r_x = (neg_x_q && (rem_x_q != '0)) ? (w_x - {1'b0, rem_x_q}) : {1'b0, rem_x_q};
		r_y = (neg_y_q && (rem_y_q != '0)) ? (w_y - {1'b0, rem_y_q}) : {1'b0, rem_y_q};
		fx  = r_x + {1'b0, win_x_min_q};
		fy  = r_y + {1'b0, win_y_min_q};
	end

	always_comb begin
		bounds_ok = (32'(x_q) < ARRAY_COLS) && (32'(y_q) < ARRAY_ROWS);
		addr_calc = AW'(x_q) * AW'(ARRAY_ROWS) + AW'(y_q);
	end

	always_comb begin
		old_pix = rd_q[PW+TW-1:TW];
		case (place_mode_q[1:0])
			sbc_pkg::RULE_OR:        new_pix = old_pix | item_q.pixel_value;
			sbc_pkg::RULE_SKIP_ZERO: new_pix = (item_q.pixel_value != '0)
				? item_q.pixel_value : old_pix;
			default:                 new_pix = item_q.pixel_value;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = {new_pix, ref_number_q};
		if (state_q == S_CLR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = '0;
		end else if (done_fire && ok_q && is_place) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem_q[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q   <= '0;
			origin_y_q   <= '0;
			win_x_min_q  <= '0;
			win_x_max_q  <= '1;
			win_y_min_q  <= '0;
			win_y_max_q  <= '1;
			ref_number_q <= '0;
			place_mode_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sbc_pkg::REG_ORIGIN_X:   origin_x_q   <= $signed(cfg_data);
				sbc_pkg::REG_ORIGIN_Y:   origin_y_q   <= $signed(cfg_data);
				sbc_pkg::REG_WIN_X_MIN:  win_x_min_q  <= cfg_data[CW-1:0];
				sbc_pkg::REG_WIN_X_MAX:  win_x_max_q  <= cfg_data[CW-1:0];
				sbc_pkg::REG_WIN_Y_MIN:  win_y_min_q  <= cfg_data[CW-1:0];
				sbc_pkg::REG_WIN_Y_MAX:  win_y_max_q  <= cfg_data[CW-1:0];
				sbc_pkg::REG_REF_NUMBER: ref_number_q <= cfg_data[TW-1:0];
				sbc_pkg::REG_PLACE_MODE: place_mode_q <= cfg_data[sbc_pkg::MODE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (done_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					div_cnt_q <= '0;
					if (is_place && tor && !empty_x && !empty_y) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_CHK;
					end
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + DCW'(1);
					if (div_cnt_q == DCW'(sbc_pkg::DIV_STEPS - 1)) begin
						state_q <= S_FIX;
					end
				end
				S_FIX:  state_q <= S_CHK;
				S_CHK:  state_q <= (ok_q && bounds_ok) ? S_READ : S_DONE;
				S_READ: state_q <= S_DONE;
				S_DONE: begin
					if (done_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers; they carry no reset.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_q <= in_data;
		end
		if (state_q == S_PREP) begin
			rem_x_q <= '0;
			rem_y_q <= '0;
			dvd_x_q <= mag_x;
			dvd_y_q <= mag_y;
			neg_x_q <= vx[VW-1];
			neg_y_q <= vy[VW-1];
			if (!is_place) begin
				x_q  <= item_q.cell_x;
				y_q  <= item_q.cell_y;
				ok_q <= 1'b1;
			end else if (tor) begin
				x_q  <= dx[CW-1:0];
				y_q  <= dy[CW-1:0];
				ok_q <= !empty_x && !empty_y;
			end else begin
				x_q  <= dx[CW-1:0];
				y_q  <= dy[CW-1:0];
				ok_q <= inwin_x && inwin_y;
			end
		end
		if (state_q == S_DIV) begin
			rem_x_q <= ts_x[CW-1:0];
			rem_y_q <= ts_y[CW-1:0];
			dvd_x_q <= {dvd_x_q[MW-2:0], 1'b0};
			dvd_y_q <= {dvd_y_q[MW-2:0], 1'b0};
		end
		if (state_q == S_FIX) begin
			x_q <= fx[CW-1:0];
			y_q <= fy[CW-1:0];
		end
		if (state_q == S_CHK) begin
			addr_q <= addr_calc;
			if (!bounds_ok) begin
				ok_q <= 1'b0;
			end
		end
		if (done_fire) begin
			if (!ok_q) begin
				out_q <= '0;
			end else begin
				out_q.dest_x    <= x_q;
				out_q.dest_y    <= y_q;
				out_q.in_window <= 1'b1;
				if (is_place) begin
					out_q.cell_pixel <= new_pix;
					out_q.cell_tag   <= ref_number_q;
				end else begin
					out_q.cell_pixel <= rd_q[PW+TW-1:TW];
					out_q.cell_tag   <= rd_q[TW-1:0];
				end
			end
		end
	end

endmodule

### design/sbc_checker.sv
// Port-level checks for sprite_blit_clip_wrap_core, bound into that core module.
// Depends on sbc_pkg for the beat structs.
module sbc_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input sbc_pkg::sbc_in_t     in_data,
	input logic                 out_valid,
	input logic                 out_ready,
	input sbc_pkg::sbc_out_t    out_data
);

	// A stalled result beat must hold.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// A waiting input beat must hold as well.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("input beat changed while waiting");

	// A clipped result carries all-zero coordinates and cell contents.
	a_clip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.in_window |-> out_data.dest_x == '0 && out_data.dest_y == '0
			&& out_data.cell_pixel == '0 && out_data.cell_tag == '0)
		else $error("clipped result with nonzero fields");

	// Items are worked one at a time: an accepted beat closes the input for the next cycle.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after an accepted beat");

	// An item never finishes in the cycle after it is taken.
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result appeared too early");

endmodule

bind sprite_blit_clip_wrap_core sbc_checker u_sbc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
